// ===== src/osac_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the oxygen sensor average and calibrate block.
// No dependencies; osac_cal and the top level import this package.
package osac_pkg;

    localparam int CFG_DATA_W    = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int VOLT_LOW_W    = 12;
    localparam int VOLT_HIGH_W   = 13;
    localparam int OFFSET_W      = 18;
    localparam int READING_W     = 18;
    localparam int FRAC_SHIFT    = 20;
    localparam int READ_LIMIT    = 100000;
    localparam int VOLT_LOW_RST  = 310;
    localparam int VOLT_HIGH_RST = 4096;

    typedef enum logic [1:0] {
        FUNC_VOLT    = 2'd0,
        FUNC_O2      = 2'd1,
        FUNC_QUERY   = 2'd2,
        FUNC_SET_CAL = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOT_CAL = 2'd1,
        ST_ABSENT  = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VOLT_LOW    = 2'd0,
        CFG_VOLT_HIGH   = 2'd1,
        CFG_CONV_FACTOR = 2'd2,
        CFG_CAL_OFFSET  = 2'd3
    } t_cfg_idx;

    // Per-item control that rides along the calibration pipeline.
    typedef struct packed {
        t_status status;
        logic    present;
        logic    calibrated;
        logic    rd_ok;
    } t_ctl;

endpackage

// ===== src/osac_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input items and the result items.
// No dependencies.
interface osac_in_if #(
    parameter int SAMPLE_BITS = 12
) ();
    logic                   valid;
    logic                   ready;
    logic [1:0]             func;
    logic [SAMPLE_BITS-1:0] sample_code;
    logic                   cal_flag;

    modport source (output valid, func, sample_code, cal_flag, input ready);
    modport sink   (input valid, func, sample_code, cal_flag, output ready);
endinterface

interface osac_out_if ();
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [17:0] reading;
    logic               present;
    logic               calibrated;

    modport source (output valid, status, reading, present, calibrated, input ready);
    modport sink   (input valid, status, reading, present, calibrated, output ready);
endinterface

// ===== src/osac_win.sv =====
`timescale 1ns / 1ps
// Circular sample window with a running sum: one read-modify-write per push.
// Standalone; used twice by the top level.
module osac_win #(
    parameter int DEPTH       = 150,
    parameter int SAMPLE_BITS = 12,
    localparam int SUM_W = $clog2(DEPTH * ((1 << SAMPLE_BITS) - 1) + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [SAMPLE_BITS-1:0] i_code,
    output logic [SUM_W-1:0]       o_sum
);

    localparam int PW = $clog2(DEPTH);

    logic [SAMPLE_BITS-1:0] r_mem [DEPTH];
    logic [SAMPLE_BITS-1:0] r_old;
    logic [PW-1:0]          r_pos;
    logic                   r_wrapped;
    logic [SUM_W-1:0]       r_sum;

    logic [PW-1:0]          pos_inc;
    logic [PW-1:0]          rd_addr;
    logic                   at_end;
    logic [SAMPLE_BITS-1:0] old_code;
    logic [SUM_W-1:0]       n_sum;

    // Until the pointer has wrapped once, the slot being replaced was never
    // written and counts as zero, which matches a cleared window.
    always_comb begin
        at_end   = (r_pos == PW'(DEPTH - 1));
        pos_inc  = at_end ? '0 : r_pos + PW'(1);
        rd_addr  = i_push ? pos_inc : r_pos;
        old_code = r_wrapped ? r_old : '0;
        n_sum    = r_sum - SUM_W'(old_code) + SUM_W'(i_code);
    end

    // The read always targets the slot the next push will replace, so its
    // old value is waiting in r_old by the time that push arrives.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_pos] <= i_code;
        end
        r_old <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_wrapped <= 1'b0;
            r_sum     <= '0;
        end else if (i_push) begin
            r_pos <= pos_inc;
            r_sum <= n_sum;
            if (at_end) begin
                r_wrapped <= 1'b1;
            end
        end
    end

    assign o_sum = r_sum;

endmodule

// ===== src/osac_cal.sv =====
`timescale 1ns / 1ps
// Calibration pipeline: q4 average of the oxygen window, gain, offset, clamp.
// Depends on osac_pkg and the osac_out_if interface.
module osac_cal import osac_pkg::*; #(
    parameter int O2_DEPTH    = 100,
    parameter int SAMPLE_BITS = 12,
    localparam int SUM_W = $clog2(O2_DEPTH * ((1 << SAMPLE_BITS) - 1) + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  t_ctl                       i_ctl,
    input  logic [SUM_W-1:0]           i_o2_sum,
    input  logic signed [CFG_DATA_W-1:0] i_factor,
    input  logic signed [OFFSET_W-1:0] i_offset,
    osac_out_if.source                 o_out
);

    localparam int X_W  = SUM_W + 4;
    localparam int PM_W = 2 * X_W;
    localparam int Q_W  = SAMPLE_BITS + 4;
    localparam int P_W  = Q_W + 1 + CFG_DATA_W;
    localparam int SH_W = P_W - FRAC_SHIFT;
    localparam int RW   = SH_W + 1;
    localparam longint unsigned RECIP = (longint'(1) << X_W) / O2_DEPTH;
    localparam logic [X_W-1:0]       RECIP_C = X_W'(RECIP);
    localparam logic [X_W-1:0]       DEPTH_C = X_W'(O2_DEPTH);
    localparam logic signed [RW-1:0] LIM_P   = RW'(READ_LIMIT);
    localparam logic signed [RW-1:0] LIM_N   = RW'(-READ_LIMIT);

    logic                 r_v1, r_v2, r_v3, r_v4;
    t_ctl                 r_ctl1, r_ctl2, r_ctl3;
    logic [X_W-1:0]       r_x1;
    logic [PM_W-1:0]      r_p1;
    logic [Q_W-1:0]       r_q2;
    logic signed [P_W-1:0] r_prod3;
    t_status              r_status;
    logic signed [READING_W-1:0] r_reading;
    logic                 r_present;
    logic                 r_calibrated;

    logic                 rdy2, rdy3, rdy4;
    logic [X_W-1:0]       x_in;
    logic [PM_W-1:0]      n_p1;
    logic [Q_W-1:0]       q0;
    logic [X_W-1:0]       rem;
    logic [Q_W-1:0]       n_q2;
    logic signed [P_W-1:0] n_prod3;
    logic signed [SH_W-1:0] shifted;
    logic signed [RW-1:0] biased;
    logic signed [RW-1:0] clamped;

    always_comb begin
        rdy4    = !r_v4 || o_out.ready;
        rdy3    = !r_v3 || rdy4;
        rdy2    = !r_v2 || rdy3;
        o_ready = !r_v1 || rdy2;
    end

    // floor(x / depth) by reciprocal: the estimate is low by at most one,
    // and the remainder check fixes it.
    always_comb begin
        x_in    = {i_o2_sum, 4'b0000};
        n_p1    = PM_W'(x_in) * PM_W'(RECIP_C);
        q0      = r_p1[X_W +: Q_W];
        rem     = r_x1 - X_W'(q0) * DEPTH_C;
        n_q2    = q0 + Q_W'(rem >= DEPTH_C);
        n_prod3 = P_W'($signed({1'b0, r_q2})) * P_W'(i_factor);
        shifted = SH_W'(r_prod3 >>> FRAC_SHIFT);
        biased  = RW'(shifted) + RW'(i_offset);
        if (biased > LIM_P) begin
            clamped = LIM_P;
        end else if (biased < LIM_N) begin
            clamped = LIM_N;
        end else begin
            clamped = biased;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_ctl1 <= i_ctl;
            r_x1   <= x_in;
            r_p1   <= n_p1;
        end
        if (rdy2) begin
            r_ctl2 <= r_ctl1;
            r_q2   <= n_q2;
        end
        if (rdy3) begin
            r_ctl3  <= r_ctl2;
            r_prod3 <= n_prod3;
        end
        if (rdy4) begin
            r_status     <= r_ctl3.status;
            r_present    <= r_ctl3.present;
            r_calibrated <= r_ctl3.calibrated;
            r_reading    <= r_ctl3.rd_ok ? READING_W'(clamped) : '0;
        end
    end

    assign o_out.valid      = r_v4;
    assign o_out.status     = r_status;
    assign o_out.reading    = r_reading;
    assign o_out.present    = r_present;
    assign o_out.calibrated = r_calibrated;

endmodule

// ===== src/oxygen_sensor_average_calibrate_core.sv =====
`timescale 1ns / 1ps
// Top level of the oxygen sensor average and calibrate block.
// Depends on osac_pkg, osac_if, osac_win and osac_cal.
//
// Usage:
//   i_in_ch carries one beat per command: a presence sample, an oxygen
//   sample, a reading query or a calibrated-flag write. o_out_ch returns
//   exactly one beat per input beat, in order, with status, reading,
//   presence and the calibrated flag after that command.
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   no command is in flight; writing the gain also sets the calibrated flag
//   when the gain is nonzero.
//   An accepted input beat reaches its output beat through an input
//   register where the window sums and flags are updated, then the
//   reciprocal multiply, the remainder fix, the gain multiply, and the
//   offset-and-clamp output register. Throughput is one beat per cycle
//   while the receiver does not stall. Each window keeps its samples in a
//   memory read one slot ahead of its write pointer, so back-to-back
//   samples into the same window are taken without a gap between them.
//   Reset clears registers to their defaults and both windows to zero at
//   once, with no clearing pass. When the receiver stalls, the pipeline
//   stages keep filling and the input stalls only when all are full.
module oxygen_sensor_average_calibrate_core import osac_pkg::*; #(
    parameter int VOLT_DEPTH  = 150,
    parameter int O2_DEPTH    = 100,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    osac_in_if.sink               i_in_ch,
    osac_out_if.source            o_out_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int VSUM_W = $clog2(VOLT_DEPTH * ((1 << SAMPLE_BITS) - 1) + 1);
    localparam int OSUM_W = $clog2(O2_DEPTH * ((1 << SAMPLE_BITS) - 1) + 1);
    localparam int TW     = $clog2(VOLT_DEPTH) + SAMPLE_BITS + 18;
    localparam logic [TW-1:0] THR_LO_RST = TW'(VOLT_DEPTH * (16 * VOLT_LOW_RST + 1));
    localparam logic [TW-1:0] THR_HI_RST = TW'(VOLT_DEPTH * (16 * VOLT_HIGH_RST));
    localparam logic [TW-1:0] DEPTH_T    = TW'(VOLT_DEPTH);

    logic                   r_s0_valid;
    t_func                  r_s0_func;
    logic [SAMPLE_BITS-1:0] r_s0_code;
    logic                   r_s0_flag;
    logic                   r_present;
    logic                   r_cal;
    logic [TW-1:0]          r_thr_lo;
    logic [TW-1:0]          r_thr_hi;
    logic signed [CFG_DATA_W-1:0] r_factor;
    logic signed [OFFSET_W-1:0]   r_offset;

    logic                   cal_ready;
    logic                   commit;
    logic                   push_v;
    logic                   push_o;
    logic [VSUM_W-1:0]      volt_sum;
    logic [OSUM_W-1:0]      o2_sum;
    logic [TW-1:0]          volt_x;
    logic                   pres_ok;
    logic                   n_present;
    logic                   n_cal;
    t_ctl                   ctl;

    assign i_in_ch.ready = !r_s0_valid || cal_ready;
    assign commit        = r_s0_valid && cal_ready;
    assign push_v        = commit && (r_s0_func == FUNC_VOLT);
    assign push_o        = commit && (r_s0_func == FUNC_O2);

    osac_win #(
        .DEPTH       (VOLT_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_volt_win (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_v),
        .i_code  (r_s0_code),
        .o_sum   (volt_sum)
    );

    osac_win #(
        .DEPTH       (O2_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_o2_win (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_o),
        .i_code  (r_s0_code),
        .o_sum   (o2_sum)
    );

    // The q4 average is never formed: floor(16*s/D) > 16*low is the same as
    // 16*s >= D*(16*low+1), and floor(16*s/D) < 16*high as 16*s < D*16*high.
    always_comb begin
        volt_x    = TW'({volt_sum, 4'b0000});
        pres_ok   = (volt_x >= r_thr_lo) && (volt_x < r_thr_hi);
        n_present = r_present;
        n_cal     = r_cal;
        ctl       = '{status: ST_OK, present: 1'b0, calibrated: 1'b0, rd_ok: 1'b0};
        case (r_s0_func)
            FUNC_QUERY: begin
                if (!r_cal) begin
                    ctl.status = ST_NOT_CAL;
                end else if (pres_ok) begin
                    n_present = 1'b1;
                    ctl.rd_ok = 1'b1;
                end else begin
                    n_present  = 1'b0;
                    n_cal      = 1'b0;
                    ctl.status = ST_ABSENT;
                end
            end
            FUNC_SET_CAL: begin
                n_cal = r_s0_flag;
            end
            default: begin
            end
        endcase
        ctl.present    = n_present;
        ctl.calibrated = n_cal;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_s0_valid <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.ready && i_in_ch.valid) begin
            r_s0_func <= t_func'(i_in_ch.func);
            r_s0_code <= SAMPLE_BITS'(i_in_ch.sample_code);
            r_s0_flag <= i_in_ch.cal_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= 1'b0;
            r_cal     <= 1'b0;
            r_thr_lo  <= THR_LO_RST;
            r_thr_hi  <= THR_HI_RST;
            r_factor  <= '0;
            r_offset  <= '0;
        end else begin
            if (commit) begin
                r_present <= n_present;
                r_cal     <= n_cal;
            end else if (i_cfg_we && (t_cfg_idx'(i_cfg_idx) == CFG_CONV_FACTOR)) begin
                r_cal <= (i_cfg_data != '0);
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_VOLT_LOW: begin
                        r_thr_lo <= DEPTH_T * TW'({i_cfg_data[VOLT_LOW_W-1:0], 4'b0001});
                    end
                    CFG_VOLT_HIGH: begin
                        r_thr_hi <= DEPTH_T * TW'({i_cfg_data[VOLT_HIGH_W-1:0], 4'b0000});
                    end
                    CFG_CONV_FACTOR: begin
                        r_factor <= $signed(i_cfg_data);
                    end
                    CFG_CAL_OFFSET: begin
                        r_offset <= $signed(i_cfg_data[OFFSET_W-1:0]);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    osac_cal #(
        .O2_DEPTH    (O2_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cal (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_s0_valid),
        .o_ready  (cal_ready),
        .i_ctl    (ctl),
        .i_o2_sum (o2_sum),
        .i_factor (r_factor),
        .i_offset (r_offset),
        .o_out    (o_out_ch)
    );

    // A query that finds the sensor absent drops both flags.
    a_absent_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && (r_s0_func == FUNC_QUERY) && r_cal && !pres_ok)
        |=> (!r_cal && !r_present))
        else $error("absent query did not clear the flags");

    // A command waiting on a full pipeline is neither lost nor altered.
    a_s0_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s0_valid && !cal_ready)
        |=> (r_s0_valid && $stable(r_s0_func) && $stable(r_s0_code)))
        else $error("stalled command changed");

    // Running sums never exceed a full window of maximum codes.
    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (volt_sum <= VSUM_W'(VOLT_DEPTH * ((1 << SAMPLE_BITS) - 1)))
        && (o2_sum <= OSUM_W'(O2_DEPTH * ((1 << SAMPLE_BITS) - 1))))
        else $error("window running sum out of range");

endmodule
